// File: sv/lqat_pkg.sv
// ----------------------------------------------------------------------------
// lqat_pkg: shared definitions for the link quality average table
// Field widths, parameter defaults, result status codes, configuration
// register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package lqat_pkg;

    // Parameter defaults.
    localparam int STATIONS_DEF   = 32;
    localparam int SAMPLES_DEF    = 8;
    localparam int CALL_CHARS_DEF = 12;

    // Fixed field widths.
    localparam int SNR_W      = 10;
    localparam int RSSI_W     = 12;
    localparam int CALL_HI_W  = 64;
    localparam int CALL_LO_W  = 32;
    localparam int KEY_W      = CALL_HI_W + CALL_LO_W;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int USED_W     = 9;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;

    // Reset values of the filter floors, in tenths of a dB.
    localparam logic signed [SNR_W-1:0]  SNR_FLOOR_RST  = -10'sd300;
    localparam logic signed [RSSI_W-1:0] RSSI_FLOOR_RST = -12'sd1500;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SNR_FLOOR  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RSSI_FLOOR = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_MISS   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_CMP,
        ST_UPDATE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } lqat_state_t;

endpackage

// File: sv/lqat_div.sv
// ----------------------------------------------------------------------------
// lqat_div: restoring unsigned divider
// Produces one quotient bit per cycle. A start pulse loads the operands;
// done pulses for one cycle once the quotient is complete.
// ----------------------------------------------------------------------------
module lqat_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic [DEN_W-1:0]  rem_next;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = (shifted >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end

    // Step counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: sv/link_quality_average_table.sv
// ----------------------------------------------------------------------------
// link_quality_average_table: per-station SNR and RSSI averaging table
// Records samples into a ring per callsign and answers queries with the
// sample count and rounded mean SNR and RSSI.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid/in_ready, mode, call_hi, call_lo,| in
//            | snr_sample, rssi_sample                   |
//   output   | out_valid/out_ready, status, sample_count,| out
//            | avg_snr, avg_rssi, stations_used          |
//   config   | cfg_wr_en, cfg_index, cfg_data            | in
//
// One item at a time. A filtered record or an empty-key item goes straight
// to the done state. Otherwise the key search reads and compares table
// entries in turn, with one more read when it ends without a match; a
// record update writes the sample ring and count; the stored samples are
// summed one by one; and two divides run on the shared restoring divider
// (NUM_W = 13 plus the count width, 17 at 8 samples), with idle and done at entry and exit.
// in_ready is high only in the idle state. A finished result sits in the
// output register, so the next item is taken while it waits for out_ready.
// No clearing pass after reset; the block is ready as soon as reset ends.
// ----------------------------------------------------------------------------
module link_quality_average_table #(
    parameter int STATIONS   = lqat_pkg::STATIONS_DEF,
    parameter int SAMPLES    = lqat_pkg::SAMPLES_DEF,
    parameter int CALL_CHARS = lqat_pkg::CALL_CHARS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [lqat_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [lqat_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [lqat_pkg::CALL_HI_W-1:0]        call_hi,
    input  logic [lqat_pkg::CALL_LO_W-1:0]        call_lo,
    input  logic signed [lqat_pkg::SNR_W-1:0]     snr_sample,
    input  logic signed [lqat_pkg::RSSI_W-1:0]    rssi_sample,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lqat_pkg::STATUS_W-1:0]         status,
    output logic [lqat_pkg::COUNT_W-1:0]          sample_count,
    output logic signed [lqat_pkg::SNR_W-1:0]     avg_snr,
    output logic signed [lqat_pkg::RSSI_W-1:0]    avg_rssi,
    output logic [lqat_pkg::USED_W-1:0]           stations_used
);

    localparam int SNR_W  = lqat_pkg::SNR_W;
    localparam int RSSI_W = lqat_pkg::RSSI_W;
    localparam int KEY_W  = lqat_pkg::KEY_W;
    localparam int IW     = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int UW     = $clog2(STATIONS + 1);
    localparam int CW     = $clog2(SAMPLES + 1);
    localparam int PW     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int DEPTH  = STATIONS * SAMPLES;
    localparam int RAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SSW    = SNR_W + CW;
    localparam int RSW    = RSSI_W + CW;
    localparam int NUM_W  = RSW + 1;
    localparam int DEN_W  = CW + 1;
    localparam int MW     = CW + PW;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]         key_mem  [STATIONS];
    logic [MW-1:0]            meta_mem [STATIONS];
    logic signed [SNR_W-1:0]  snr_mem  [DEPTH];
    logic signed [RSSI_W-1:0] rssi_mem [DEPTH];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    lqat_pkg::lqat_state_t    state_reg;
    lqat_pkg::lqat_state_t    state_next;

    logic signed [SNR_W-1:0]  snr_floor_reg;
    logic signed [RSSI_W-1:0] rssi_floor_reg;
    logic [UW-1:0]            used_reg;
    logic                     out_valid_reg;

    logic                     mode_reg;
    logic [KEY_W-1:0]         key_reg;
    logic signed [SNR_W-1:0]  snr_reg;
    logic signed [RSSI_W-1:0] rssi_reg;
    logic [UW-1:0]            idx_reg;
    logic [RAW-1:0]           base_reg;
    logic [CW-1:0]            cnt_reg;
    logic [PW-1:0]            ptr_reg;
    logic [CW-1:0]            smp_idx_reg;
    logic signed [SSW-1:0]    acc_snr_reg;
    logic signed [RSW-1:0]    acc_rssi_reg;
    logic                     div_sel_reg;

    logic [KEY_W-1:0]         key_rd_reg;
    logic [MW-1:0]            meta_rd_reg;
    logic signed [SNR_W-1:0]  snr_rd_reg;
    logic signed [RSSI_W-1:0] rssi_rd_reg;

    lqat_pkg::status_t        res_status_reg;
    logic [CW-1:0]            res_count_reg;
    logic signed [SNR_W-1:0]  res_snr_reg;
    logic signed [RSSI_W-1:0] res_rssi_reg;

    lqat_pkg::status_t        out_status_reg;
    logic [CW-1:0]            out_count_reg;
    logic signed [SNR_W-1:0]  out_snr_reg;
    logic signed [RSSI_W-1:0] out_rssi_reg;
    logic [UW-1:0]            out_used_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                     in_fire;
    logic                     out_free;
    logic [KEY_W-1:0]         key_form;
    logic                     key_empty;
    logic                     rec_reject;
    logic                     early_done;
    logic                     scan_end;
    logic                     key_hit;
    logic                     table_full;
    logic                     append;
    logic                     sum_last;
    logic [PW-1:0]            ptr_eff;
    logic [PW-1:0]            ptr_wrap;
    logic [CW-1:0]            cnt_new;
    logic [RAW-1:0]           ring_waddr;
    logic [RAW-1:0]           ring_raddr;
    logic [RAW-1:0]           base_new;
    logic                     div_start;
    logic                     div_done;
    logic signed [RSW-1:0]    div_sum;
    logic                     div_neg;
    logic [RSW-1:0]           div_mag;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic [NUM_W-1:0]         div_quot;
    logic [NUM_W-1:0]         div_res;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Key forming: a zero character ends the callsign, and only the first
    // CALL_CHARS characters count.
    always_comb
    begin
        logic       ended;
        logic [7:0] ch;
        ended    = 1'b0;
        key_form = '0;
        for (int i = 0; i < 12; i++)
        begin
            if (i < 8)
            begin
                ch = call_hi[8*(7-i) +: 8];
            end
            else
            begin
                ch = call_lo[8*(11-i) +: 8];
            end
            if (i >= CALL_CHARS || ch == 8'd0)
            begin
                ended = 1'b1;
            end
            if (ended)
            begin
                ch = 8'd0;
            end
            key_form[8*(11-i) +: 8] = ch;
        end
    end

    // Acceptance decisions.
    assign key_empty  = (key_form == '0);
    assign rec_reject = key_empty || (snr_sample <= snr_floor_reg)
                        || (rssi_sample <= rssi_floor_reg);
    assign early_done = mode ? key_empty : rec_reject;

    // Search and append decisions.
    assign scan_end   = (idx_reg >= used_reg);
    assign key_hit    = (key_rd_reg == key_reg);
    assign table_full = (used_reg == UW'(STATIONS));
    assign append     = (state_reg == lqat_pkg::ST_KEY_RD) && scan_end
                        && !mode_reg && !table_full;
    assign base_new   = RAW'(idx_reg * SAMPLES);

    // Ring pointer, count update and addresses.
    always_comb
    begin
        ptr_eff  = ({1'b0, ptr_reg} >= (PW+1)'(SAMPLES)) ? '0 : ptr_reg;
        ptr_wrap = (({1'b0, ptr_eff} + (PW+1)'(1)) >= (PW+1)'(SAMPLES))
                   ? '0 : (ptr_eff + PW'(1));
        cnt_new  = (cnt_reg < CW'(SAMPLES)) ? (cnt_reg + CW'(1)) : cnt_reg;
    end

    assign ring_waddr = base_reg + RAW'(ptr_eff);
    assign ring_raddr = base_reg + RAW'(smp_idx_reg);
    assign sum_last   = ((smp_idx_reg + CW'(1)) >= cnt_reg);

    // Divider operands: rounded mean = (2|sum| + n) / (2n), sign restored.
    always_comb
    begin
        div_sum = div_sel_reg ? acc_rssi_reg : RSW'(acc_snr_reg);
        div_neg = div_sum[RSW-1];
        div_mag = div_neg ? RSW'(-div_sum) : RSW'(div_sum);
        div_num = {div_mag, 1'b0} + NUM_W'(cnt_reg);
        div_den = {cnt_reg, 1'b0};
        div_res = div_neg ? (NUM_W'(0) - div_quot) : div_quot;
    end

    lqat_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lqat_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            lqat_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = early_done ? lqat_pkg::ST_DONE : lqat_pkg::ST_KEY_RD;
                end
            end
            lqat_pkg::ST_KEY_RD:
            begin
                if (scan_end)
                begin
                    state_next = (mode_reg || table_full) ? lqat_pkg::ST_DONE
                                                          : lqat_pkg::ST_UPDATE;
                end
                else
                begin
                    state_next = lqat_pkg::ST_KEY_CMP;
                end
            end
            lqat_pkg::ST_KEY_CMP:
            begin
                if (key_hit)
                begin
                    state_next = mode_reg ? lqat_pkg::ST_SUM_RD : lqat_pkg::ST_UPDATE;
                end
                else
                begin
                    state_next = lqat_pkg::ST_KEY_RD;
                end
            end
            lqat_pkg::ST_UPDATE:
            begin
                state_next = lqat_pkg::ST_SUM_RD;
            end
            lqat_pkg::ST_SUM_RD:
            begin
                state_next = lqat_pkg::ST_SUM_ACC;
            end
            lqat_pkg::ST_SUM_ACC:
            begin
                state_next = sum_last ? lqat_pkg::ST_DIV_GO : lqat_pkg::ST_SUM_RD;
            end
            lqat_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = lqat_pkg::ST_DIV_WAIT;
            end
            lqat_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = div_sel_reg ? lqat_pkg::ST_DONE : lqat_pkg::ST_DIV_GO;
                end
            end
            lqat_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lqat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lqat_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers: floors, table fill count, output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snr_floor_reg  <= lqat_pkg::SNR_FLOOR_RST;
            rssi_floor_reg <= lqat_pkg::RSSI_FLOOR_RST;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lqat_pkg::CFG_SNR_FLOOR:  snr_floor_reg  <= cfg_data[SNR_W-1:0];
                    lqat_pkg::CFG_RSSI_FLOOR: rssi_floor_reg <= cfg_data[RSSI_W-1:0];
                    default:                  ;
                endcase
            end
            if (append)
            begin
                used_reg <= used_reg + UW'(1);
            end
            if (state_reg == lqat_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lqat_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    mode_reg       <= mode;
                    key_reg        <= key_form;
                    snr_reg        <= snr_sample;
                    rssi_reg       <= rssi_sample;
                    idx_reg        <= '0;
                    smp_idx_reg    <= '0;
                    acc_snr_reg    <= '0;
                    acc_rssi_reg   <= '0;
                    div_sel_reg    <= 1'b0;
                    res_count_reg  <= '0;
                    res_snr_reg    <= '0;
                    res_rssi_reg   <= '0;
                    if (!early_done)
                    begin
                        res_status_reg <= lqat_pkg::STATUS_OK;
                    end
                    else if (mode)
                    begin
                        res_status_reg <= lqat_pkg::STATUS_MISS;
                    end
                    else
                    begin
                        res_status_reg <= lqat_pkg::STATUS_REJECT;
                    end
                end
            end
            lqat_pkg::ST_KEY_RD:
            begin
                if (scan_end)
                begin
                    if (mode_reg)
                    begin
                        res_status_reg <= lqat_pkg::STATUS_MISS;
                    end
                    else if (table_full)
                    begin
                        res_status_reg <= lqat_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        // New station: empty ring at the next free entry.
                        cnt_reg  <= '0;
                        ptr_reg  <= '0;
                        base_reg <= base_new;
                    end
                end
            end
            lqat_pkg::ST_KEY_CMP:
            begin
                if (key_hit)
                begin
                    cnt_reg  <= meta_rd_reg[MW-1:PW];
                    ptr_reg  <= meta_rd_reg[PW-1:0];
                    base_reg <= base_new;
                end
                else
                begin
                    idx_reg <= idx_reg + UW'(1);
                end
            end
            lqat_pkg::ST_UPDATE:
            begin
                cnt_reg <= cnt_new;
            end
            lqat_pkg::ST_SUM_ACC:
            begin
                acc_snr_reg  <= acc_snr_reg + SSW'(snr_rd_reg);
                acc_rssi_reg <= acc_rssi_reg + RSW'(rssi_rd_reg);
                smp_idx_reg  <= smp_idx_reg + CW'(1);
                if (sum_last)
                begin
                    res_count_reg <= cnt_reg;
                end
            end
            lqat_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    div_sel_reg <= 1'b1;
                    if (div_sel_reg)
                    begin
                        res_rssi_reg <= div_res[RSSI_W-1:0];
                    end
                    else
                    begin
                        res_snr_reg <= div_res[SNR_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Output register, loaded when the previous result has been taken.
        if (state_reg == lqat_pkg::ST_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
            out_snr_reg    <= res_snr_reg;
            out_rssi_reg   <= res_rssi_reg;
            out_used_reg   <= used_reg;
        end
    end

    // ------------------------------------------------------------------
    // Memories: key, count/pointer and sample rings
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            key_mem[idx_reg[IW-1:0]] <= key_reg;
        end
        key_rd_reg <= key_mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lqat_pkg::ST_UPDATE)
        begin
            meta_mem[idx_reg[IW-1:0]] <= {cnt_new, ptr_wrap};
        end
        meta_rd_reg <= meta_mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lqat_pkg::ST_UPDATE)
        begin
            snr_mem[ring_waddr] <= snr_reg;
        end
        snr_rd_reg <= snr_mem[ring_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lqat_pkg::ST_UPDATE)
        begin
            rssi_mem[ring_waddr] <= rssi_reg;
        end
        rssi_rd_reg <= rssi_mem[ring_raddr];
    end

    // ------------------------------------------------------------------
    // Output ports
    // ------------------------------------------------------------------
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign sample_count  = lqat_pkg::COUNT_W'(out_count_reg);
    assign avg_snr       = out_snr_reg;
    assign avg_rssi      = out_rssi_reg;
    assign stations_used = lqat_pkg::USED_W'(out_used_reg);

endmodule

// File: tb/tb_link_quality_average_table.sv
// ----------------------------------------------------------------------------
// tb_link_quality_average_table: self-checking bench for the link quality table
// Drives record and query transfers with random idle gaps on both channels,
// predicts each result with an independent model of the station table, and
// compares every result field by field in arrival order. The run covers the
// filter floors at their extremes, the ring wrap, rounding of halves, callsign
// termination, the full table and a long output stall.
// ----------------------------------------------------------------------------
module tb_link_quality_average_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATIONS       = lqat_pkg::STATIONS_DEF;
    localparam int SAMPLES        = lqat_pkg::SAMPLES_DEF;
    localparam int CALL_CHARS     = lqat_pkg::CALL_CHARS_DEF;
    localparam int KEY_W          = lqat_pkg::KEY_W;
    localparam int CALL_HI_W      = lqat_pkg::CALL_HI_W;
    localparam int CALL_LO_W      = lqat_pkg::CALL_LO_W;
    localparam int SNR_W          = lqat_pkg::SNR_W;
    localparam int RSSI_W         = lqat_pkg::RSSI_W;
    localparam int STATUS_W       = lqat_pkg::STATUS_W;
    localparam int COUNT_W        = lqat_pkg::COUNT_W;
    localparam int USED_W         = lqat_pkg::USED_W;
    localparam int CFG_ADDR_W     = lqat_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W     = lqat_pkg::CFG_DATA_W;
    localparam int KEY_BYTES      = KEY_W / 8;
    localparam int POOL_SIZE      = 48;
    localparam int EARLY_STATIONS = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 200;

    // Item modes.
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct {
        logic                     mode;
        logic [CALL_HI_W-1:0]     call_hi;
        logic [CALL_LO_W-1:0]     call_lo;
        logic signed [SNR_W-1:0]  snr;
        logic signed [RSSI_W-1:0] rssi;
    } radio_item_t;

    typedef struct {
        lqat_pkg::status_t        status;
        logic [COUNT_W-1:0]       count;
        logic signed [SNR_W-1:0]  avg_snr;
        logic signed [RSSI_W-1:0] avg_rssi;
        logic [USED_W-1:0]        used;
    } lq_result_t;

    // Block ports.
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     mode = MODE_RECORD;
    logic [CALL_HI_W-1:0]     call_hi = '0;
    logic [CALL_LO_W-1:0]     call_lo = '0;
    logic signed [SNR_W-1:0]  snr_sample = '0;
    logic signed [RSSI_W-1:0] rssi_sample = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       sample_count;
    logic signed [SNR_W-1:0]  avg_snr;
    logic signed [RSSI_W-1:0] avg_rssi;
    logic [USED_W-1:0]        stations_used;

    link_quality_average_table dut (.*);

    always #2 clk = ~clk;

    // Predicted table contents and floors.
    logic [KEY_W-1:0] known_calls [STATIONS];
    int               calls_known;
    int               snr_hist [STATIONS][SAMPLES];
    int               rssi_hist [STATIONS][SAMPLES];
    int               hist_fill [STATIONS];
    int               hist_next [STATIONS];
    int               snr_floor_now;
    int               rssi_floor_now;

    // Run bookkeeping.
    lq_result_t       station_reports_due [$];
    logic [KEY_W-1:0] station_pool [POOL_SIZE];
    int               error_count = 0;
    int               items_sent = 0;
    int               results_seen = 0;
    int               status_tally [4] = '{0, 0, 0, 0};
    int               stuck_cycles = 0;
    bit               quiet = 1'b0;
    bit               hold_pending = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Only the first CALL_CHARS characters count, and a zero character ends
    // the callsign.
    function automatic logic [KEY_W-1:0] callsign_key(logic [CALL_HI_W-1:0] hi,
                                                      logic [CALL_LO_W-1:0] lo);
        logic [KEY_W-1:0] raw;
        logic [KEY_W-1:0] key;
        bit               ended;
        raw   = {hi, lo};
        key   = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (i >= CALL_CHARS || raw[KEY_W-1-8*i -: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                key[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
        end
        return key;
    endfunction

    // Mean rounded to an integer, halves away from zero.
    function automatic int rounded_mean(longint sum, int n);
        longint d;
        if (n == 0)
            return 0;
        d = n;
        if (sum >= 0)
            return int'((2 * sum + d) / (2 * d));
        return -int'((-2 * sum + d) / (2 * d));
    endfunction

    function automatic void load_averages(input int idx, inout lq_result_t r);
        longint snr_sum;
        longint rssi_sum;
        int     n;
        snr_sum  = 0;
        rssi_sum = 0;
        n = (hist_fill[idx] > SAMPLES) ? SAMPLES : hist_fill[idx];
        for (int i = 0; i < n; i++)
        begin
            snr_sum  += snr_hist[idx][i];
            rssi_sum += rssi_hist[idx][i];
        end
        r.count    = COUNT_W'(n);
        r.avg_snr  = SNR_W'(rounded_mean(snr_sum, n));
        r.avg_rssi = RSSI_W'(rounded_mean(rssi_sum, n));
    endfunction

    function automatic lq_result_t predict_station_report(radio_item_t it);
        lq_result_t       r;
        logic [KEY_W-1:0] key;
        int               idx;
        int               snr_v;
        int               rssi_v;
        int               slot;
        key        = callsign_key(it.call_hi, it.call_lo);
        r.status   = lqat_pkg::STATUS_OK;
        r.count    = '0;
        r.avg_snr  = '0;
        r.avg_rssi = '0;
        idx        = -1;
        if (key != '0)
        begin
            for (int e = 0; e < calls_known; e++)
                if (idx < 0 && known_calls[e] == key)
                    idx = e;
        end
        if (it.mode == MODE_QUERY)
        begin
            if (idx < 0)
                r.status = lqat_pkg::STATUS_MISS;
            else
                load_averages(idx, r);
        end
        else
        begin
            snr_v  = it.snr;
            rssi_v = it.rssi;
            if (key == '0 || snr_v <= snr_floor_now || rssi_v <= rssi_floor_now)
            begin
                r.status = lqat_pkg::STATUS_REJECT;
            end
            else if (idx < 0 && calls_known >= STATIONS)
            begin
                r.status = lqat_pkg::STATUS_FULL;
            end
            else
            begin
                // A new station is appended with an empty ring.
                if (idx < 0)
                begin
                    idx              = calls_known;
                    known_calls[idx] = key;
                    hist_fill[idx]   = 0;
                    hist_next[idx]   = 0;
                    calls_known++;
                end
                slot                 = hist_next[idx];
                snr_hist[idx][slot]  = snr_v;
                rssi_hist[idx][slot] = rssi_v;
                if (hist_fill[idx] < SAMPLES)
                    hist_fill[idx]++;
                hist_next[idx] = (slot + 1 < SAMPLES) ? slot + 1 : 0;
                load_averages(idx, r);
            end
        end
        r.used = USED_W'(calls_known);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic logic [KEY_W-1:0] text_call(string s);
        logic [KEY_W-1:0] raw;
        raw = '0;
        for (int i = 0; i < s.len() && i < KEY_BYTES; i++)
            raw[KEY_W-1-8*i -: 8] = s[i];
        return raw;
    endfunction

    function automatic logic [KEY_W-1:0] random_call();
        string            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-/";
        logic [KEY_W-1:0] raw;
        int               len;
        raw = '0;
        len = $urandom_range(3, KEY_BYTES);
        raw[KEY_W-1 -: 8] = 8'(65 + $urandom_range(0, 25));
        for (int i = 1; i < len; i++)
            raw[KEY_W-1-8*i -: 8] = alphabet[$urandom_range(0, alphabet.len() - 1)];
        return raw;
    endfunction

    // Junk after the terminating zero must not change the key.
    function automatic logic [KEY_W-1:0] add_tail_noise(logic [KEY_W-1:0] raw);
        int z;
        z = KEY_BYTES;
        for (int i = KEY_BYTES - 1; i >= 0; i--)
            if (raw[KEY_W-1-8*i -: 8] == 8'h00)
                z = i;
        for (int i = z + 1; i < KEY_BYTES; i++)
            raw[KEY_W-1-8*i -: 8] = 8'($urandom);
        return raw;
    endfunction

    function automatic logic signed [SNR_W-1:0] pick_snr();
        case ($urandom_range(0, 19))
            0, 1, 2: return SNR_W'($urandom);
            3, 4:    return SNR_W'(snr_floor_now + int'($urandom_range(0, 2)) - 1);
            default: return SNR_W'(int'($urandom_range(0, 690)) - 290);
        endcase
    endfunction

    function automatic logic signed [RSSI_W-1:0] pick_rssi();
        case ($urandom_range(0, 19))
            0, 1, 2: return RSSI_W'($urandom);
            3, 4:    return RSSI_W'(rssi_floor_now + int'($urandom_range(0, 2)) - 1);
            default: return RSSI_W'(int'($urandom_range(0, 1490)) - 1490);
        endcase
    endfunction

    function automatic radio_item_t make_item(logic m, logic [KEY_W-1:0] call,
                                              int snr_v, int rssi_v);
        radio_item_t it;
        it.mode                 = m;
        {it.call_hi, it.call_lo} = call;
        it.snr                  = SNR_W'(snr_v);
        it.rssi                 = RSSI_W'(rssi_v);
        return it;
    endfunction

    // Mostly well-formed traffic on known stations, the rest empty keys and
    // random callsigns that never enter the table.
    function automatic radio_item_t random_radio_item(int active);
        radio_item_t      it;
        logic [KEY_W-1:0] call;
        int               roll;
        roll = $urandom_range(0, 99);
        call = station_pool[$urandom_range(0, active - 1)];
        if ($urandom_range(0, 7) == 0)
            call = add_tail_noise(call);
        it = make_item(MODE_RECORD, call, pick_snr(), pick_rssi());
        if (roll >= 68 && roll < 93)
        begin
            it.mode = MODE_QUERY;
        end
        else if (roll >= 93 && roll < 96)
        begin
            call    = {$urandom, $urandom, $urandom};
            call[KEY_W-1 -: 8] = 8'h00;
            it.mode = 1'($urandom);
        end
        else if (roll >= 96)
        begin
            call = {$urandom, $urandom, $urandom};
            if ($urandom_range(0, 1) == 1)
                it.mode = MODE_QUERY;
            else
                it.snr = snr_floor_now[SNR_W-1:0];
        end
        {it.call_hi, it.call_lo} = call;
        return it;
    endfunction

    task automatic build_pool();
        bit dup;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            do
            begin
                station_pool[i] = random_call();
                dup = 1'b0;
                for (int j = 0; j < i; j++)
                    if (station_pool[j] == station_pool[i])
                        dup = 1'b1;
            end
            while (dup);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offers one item and returns at the edge where it is accepted. Valid is
    // left high so that a back-to-back item needs no second assignment.
    task automatic send_item(input radio_item_t it);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= it.mode;
        call_hi     <= it.call_hi;
        call_lo     <= it.call_lo;
        snr_sample  <= it.snr;
        rssi_sample <= it.rssi;
        station_reports_due.push_back(predict_station_report(it));
        items_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_record(input logic [KEY_W-1:0] call, input int snr_v,
                               input int rssi_v);
        send_item(make_item(MODE_RECORD, call, snr_v, rssi_v));
    endtask

    task automatic send_query(input logic [KEY_W-1:0] call);
        send_item(make_item(MODE_QUERY, call, 0, 0));
    endtask

    // Every item gives one result, so the block is idle once all are back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (station_reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index, input int value);
        logic [CFG_DATA_W-1:0] bits;
        bits = CFG_DATA_W'(value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= bits;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == lqat_pkg::CFG_SNR_FLOOR)
            snr_floor_now = $signed(bits[SNR_W-1:0]);
        else
            rssi_floor_now = $signed(bits[RSSI_W-1:0]);
        @(posedge clk);
    endtask

    task automatic set_floors(input int snr_f, input int rssi_f);
        drain_results();
        write_reg(lqat_pkg::CFG_SNR_FLOOR, snr_f);
        write_reg(lqat_pkg::CFG_RSSI_FLOOR, rssi_f);
    endtask

    // Samples at and just above the current floors on one station.
    task automatic probe_floors(input logic [KEY_W-1:0] call);
        send_record(call, snr_floor_now, rssi_floor_now + 1);
        send_record(call, snr_floor_now + 1, rssi_floor_now + 1);
        send_record(call, snr_floor_now + 1, rssi_floor_now);
        send_query(call);
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string field, input longint want,
                                   input longint got);
        error_count++;
        $display("%0t: result %0d, %s expected %0d, got %0d",
                 $time, results_seen, field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        lq_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (station_reports_due.size() == 0)
            begin
                report_mismatch("unexpected transfer, status", -1, status);
            end
            else
            begin
                want = station_reports_due.pop_front();
                status_tally[int'(want.status)]++;
                if (status !== want.status)
                    report_mismatch("status", want.status, status);
                if (sample_count !== want.count)
                    report_mismatch("sample_count", want.count, sample_count);
                if (avg_snr !== want.avg_snr)
                    report_mismatch("avg_snr", want.avg_snr, avg_snr);
                if (avg_rssi !== want.avg_rssi)
                    report_mismatch("avg_rssi", want.avg_rssi, avg_rssi);
                if (stations_used !== want.used)
                    report_mismatch("stations_used", want.used, stations_used);
            end
            results_seen++;
        end
    end

    // Result side: random stalls, or a long hold when a test asks for one.
    initial
    begin : result_receiver
        int idle_left;
        idle_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                idle_left    = HOLD_CYCLES;
            end
            else if (idle_left == 0 && !quiet && $urandom_range(0, 2) == 0)
            begin
                idle_left = pick_gap();
            end
            if (idle_left > 0)
            begin
                out_ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty keys, floors, full-scale sample values, callsign termination, rounding
    // of halves and the ring wrap, all at the reset floors.
    task automatic test_directed();
        logic [KEY_W-1:0] call_a;
        logic [KEY_W-1:0] call_b;
        logic [KEY_W-1:0] call_ring;
        logic [KEY_W-1:0] call_ones;
        logic [KEY_W-1:0] junk_empty;
        call_a     = text_call("KX9QRS-15/P");
        call_b     = text_call("QX7TST");
        call_ring  = text_call("RING1");
        call_ones  = '1;
        junk_empty = {8'h00, 88'h5A_A5F0_0F12_3456_789A_BCDE};
        send_query('0);
        send_record('0, 100, -500);
        send_record(junk_empty, 100, -500);
        send_query(call_a);
        send_record(call_a, 400, 0);
        send_record(call_a, -299, -1499);
        send_record(call_a, -300, -1000);
        send_record(call_a, 100, -1500);
        send_record(call_a, 511, 2047);
        send_record(call_a, -512, -2048);
        send_query(add_tail_noise(call_a));
        send_record(text_call("VK2ZZZ-10/MM"), 0, -800);
        send_record(call_ones, 0, -1);
        send_query(call_ones);
        // Means of 1.5 and -1.5 round away from zero.
        send_record(call_b, 1, -1);
        send_record(call_b, 2, -2);
        send_query(call_b);
        // Nine samples into a ring of eight.
        for (int i = 0; i < SAMPLES + 1; i++)
            send_record(call_ring, 37 * i - 35, -97 * i - 3);
    endtask

    task automatic test_floor_extremes();
        set_floors(-512, -2048);
        probe_floors(station_pool[0]);
        set_floors(-400, -2000);
        probe_floors(station_pool[1]);
        set_floors(400, 0);
        probe_floors(station_pool[2]);
        send_record(station_pool[2], 401, 1);
        set_floors(511, 2047);
        probe_floors(station_pool[3]);
        set_floors(-300, -1500);
        probe_floors(station_pool[3]);
    endtask

    task automatic test_random_traffic();
        repeat (500)
            send_item(random_radio_item(EARLY_STATIONS));
        set_floors(int'($urandom_range(0, 200)) - 400, int'($urandom_range(0, 800)) - 2000);
        // A stretch with no idling on either side.
        quiet = 1'b1;
        repeat (150)
            send_item(random_radio_item(EARLY_STATIONS));
        quiet = 1'b0;
        repeat (350)
            send_item(random_radio_item(EARLY_STATIONS));
        set_floors(-400, -2000);
        repeat (500)
            send_item(random_radio_item(EARLY_STATIONS));
    endtask

    // The receiver holds off while items keep coming, so the output register
    // fills and the block stops taking input.
    task automatic test_input_stall();
        hold_pending = 1'b1;
        quiet        = 1'b1;
        repeat (30)
            send_item(random_radio_item(EARLY_STATIONS));
        quiet = 1'b0;
    endtask

    // New stations until the table is full, then more that must be refused.
    task automatic test_table_full();
        int roll;
        repeat (160)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 5)
                send_record(station_pool[$urandom_range(0, POOL_SIZE - 1)],
                            pick_snr(), pick_rssi());
            else if (roll < 7)
                send_record({$urandom, $urandom, $urandom}, pick_snr(), pick_rssi());
            else
                send_query(station_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        calls_known    = 0;
        snr_floor_now  = -300;
        rssi_floor_now = -1500;
        build_pool();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_floor_extremes();
        test_random_traffic();
        test_input_stall();
        test_table_full();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (station_reports_due.size() != 0)
            report_mismatch("results still outstanding", 0, station_reports_due.size());
        $display("Sent %0d items and checked %0d results; %0d stations ended in the table.",
                 items_sent, results_seen, calls_known);
        $display("Results by status: done %0d, rejected %0d, table full %0d, unknown %0d.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
